### hdl/console_cpu_bus_decoder_macros.svh
// Assertion macros for the console CPU bus decoder.
// Included by ccbd_ctrl, which carries concurrent assertions; no other dependencies.
`ifndef CONSOLE_CPU_BUS_DECODER_MACROS_SVH
`define CONSOLE_CPU_BUS_DECODER_MACROS_SVH

// Same-cycle implication, disabled during reset.
`define CCBD_ASSERT_IMP(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("ccbd: same-cycle check failed");

// Next-cycle implication, disabled during reset.
`define CCBD_ASSERT_NXT(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("ccbd: next-cycle check failed");

`endif

### hdl/ccbd_pkg.sv
// Shared types, constants and helper functions for the console CPU bus decoder.
// Used by ccbd_ctrl, ccbd_datapath and console_cpu_bus_decoder; no dependencies.
`timescale 1ns / 1ps
`default_nettype none

package ccbd_pkg;

  localparam int unsigned CPU_RAM_BYTES_DEF   = 8192;
  localparam int unsigned VIDEO_RAM_BYTES_DEF = 8192;
  localparam int unsigned IO_BYTES_DEF        = 32;

  typedef enum logic [2:0] {
    OP_CPU_WRITE    = 3'd0,
    OP_CPU_READ     = 3'd1,
    OP_VRAM_READ    = 3'd2,
    OP_SET_VBLANK   = 3'd3,
    OP_CLEAR_VBLANK = 3'd4,
    OP_LOAD_BUTTONS = 3'd5
  } op_t;

  localparam logic [2:0] REG_CTRL   = 3'd0;
  localparam logic [2:0] REG_STATUS = 3'd2;
  localparam logic [2:0] REG_SCROLL = 3'd5;
  localparam logic [2:0] REG_ADDR   = 3'd6;
  localparam logic [2:0] REG_DATA   = 3'd7;

  localparam logic [15:0] PPU_BASE      = 16'h2000;
  localparam logic [15:0] IO_BASE       = 16'h4000;
  localparam logic [15:0] UNMAPPED_BASE = 16'h4020;
  localparam logic [15:0] JOYPAD_ADDR   = 16'h4016;

  localparam int unsigned VBLANK_BIT   = 7;
  localparam int unsigned CTRL_INC_BIT = 2;
  localparam int unsigned VADDR_W      = 14;
  localparam logic [VADDR_W-1:0] INC_ROW = 14'd32;
  localparam logic [VADDR_W-1:0] INC_COL = 14'd1;

  typedef enum logic [1:0] {
    SRC_BYTE,
    SRC_CPU_RAM,
    SRC_VRAM
  } rd_src_t;

  typedef enum logic {
    ST_IDLE,
    ST_FINISH
  } state_t;

  typedef struct packed {
    logic accept;
    logic load_out;
  } cmd_t;

  // Reduces a 13-bit offset into a window of at least 2048 bytes.
  function automatic logic [12:0] wrap_index(input logic [12:0] v, input logic [13:0] m);
    logic [13:0] r;
    r = {1'b0, v};
    for (int i = 0; i < 4; i++) begin
      if (r >= m) begin
        r = r - m;
      end
    end
    return r[12:0];
  endfunction

endpackage

`default_nettype wire

### hdl/ccbd_ctrl.sv
// Request sequencer for the console CPU bus decoder: state machine and result valid.
// Depends on ccbd_pkg and console_cpu_bus_decoder_macros.svh.
`timescale 1ns / 1ps
`default_nettype none
`include "console_cpu_bus_decoder_macros.svh"

module ccbd_ctrl (
  input  wire logic          clk,
  input  wire logic          rst,
  input  wire logic          in_valid,
  output logic               in_ready,
  output logic               out_valid,
  input  wire logic          out_ready,
  output ccbd_pkg::cmd_t     cmd
);

  ccbd_pkg::state_t state;
  ccbd_pkg::state_t state_next;
  logic             out_free;

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= ccbd_pkg::ST_IDLE;
      out_valid <= 1'b0;
    end else begin
      state <= state_next;
      if (cmd.load_out) begin
        out_valid <= 1'b1;
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
    end
  end

  always_comb begin
    out_free     = !out_valid || out_ready;
    state_next   = state;
    in_ready     = 1'b0;
    cmd.accept   = 1'b0;
    cmd.load_out = 1'b0;
    case (state)
      ccbd_pkg::ST_IDLE: begin
        in_ready = 1'b1;
        if (in_valid) begin
          cmd.accept = 1'b1;
          state_next = ccbd_pkg::ST_FINISH;
        end
      end
      ccbd_pkg::ST_FINISH: begin
        if (out_free) begin
          cmd.load_out = 1'b1;
          in_ready     = 1'b1;
          if (in_valid) begin
            cmd.accept = 1'b1;
          end else begin
            state_next = ccbd_pkg::ST_IDLE;
          end
        end
      end
      default: begin
        state_next = ccbd_pkg::ST_IDLE;
      end
    endcase
  end

  `CCBD_ASSERT_NXT(a_accept_finishes, clk, rst, cmd.accept, state == ccbd_pkg::ST_FINISH)
  `CCBD_ASSERT_IMP(a_result_moves, clk, rst, (state == ccbd_pkg::ST_FINISH) && out_free, cmd.load_out)
  `CCBD_ASSERT_NXT(a_load_shows_result, clk, rst, cmd.load_out, out_valid)

endmodule

`default_nettype wire

### hdl/ccbd_datapath.sv
// Datapath of the console CPU bus decoder: address decode, register file, RAMs,
// video address latch, scroll pair, controller shift register and result register.
// Depends on ccbd_pkg.
`timescale 1ns / 1ps
`default_nettype none

module ccbd_datapath #(
  parameter int unsigned CPU_RAM_BYTES   = ccbd_pkg::CPU_RAM_BYTES_DEF,
  parameter int unsigned VIDEO_RAM_BYTES = ccbd_pkg::VIDEO_RAM_BYTES_DEF,
  parameter int unsigned IO_BYTES        = ccbd_pkg::IO_BYTES_DEF
) (
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire ccbd_pkg::cmd_t cmd,
  input  wire logic [2:0]  operation,
  input  wire logic [15:0] address,
  input  wire logic [7:0]  data,
  output logic      [7:0]  read_data,
  output logic             unmapped,
  output logic      [7:0]  scroll_x,
  output logic      [7:0]  scroll_y,
  output logic             vblank
);

  localparam int unsigned CPU_IDX_W  = $clog2(CPU_RAM_BYTES);
  localparam int unsigned VRAM_IDX_W = $clog2(VIDEO_RAM_BYTES);
  localparam int unsigned IO_IDX_W   = $clog2(IO_BYTES);
  localparam int unsigned VW         = ccbd_pkg::VADDR_W;

  logic [7:0] cpu_ram   [CPU_RAM_BYTES];
  logic [7:0] video_ram [VIDEO_RAM_BYTES];
  logic [7:0] ppu_regs      [8];
  logic [7:0] ppu_regs_next [8];
  logic [7:0] io_bytes  [IO_BYTES];

  logic [VW-1:0] video_address;
  logic [VW-1:0] video_address_next;
  logic [15:0]   scroll_pair;
  logic [15:0]   scroll_pair_next;
  logic [7:0]    button_state;
  logic [7:0]    button_state_next;
  logic [7:0]    button_shift;
  logic [7:0]    button_shift_next;

  ccbd_pkg::op_t     op;
  ccbd_pkg::rd_src_t src;
  ccbd_pkg::rd_src_t pend_src;
  logic [7:0]  byte_val;
  logic        unm;
  logic        cpu_we;
  logic        vram_we;
  logic        io_we;
  logic        in_ram;
  logic        in_ppu;
  logic        in_io;
  logic [2:0]  reg_num;
  logic [12:0] cpu_off;
  logic [12:0] vram_wr_off;
  logic [12:0] vram_rd_off;
  logic [CPU_IDX_W-1:0]  cpu_idx;
  logic [VRAM_IDX_W-1:0] vram_wr_idx;
  logic [VRAM_IDX_W-1:0] vram_rd_idx;
  logic [IO_IDX_W-1:0]   io_idx;

  logic [7:0]  pend_byte;
  logic        pend_unmapped;
  logic [15:0] pend_scroll;
  logic        pend_vblank;
  logic [7:0]  cpu_ram_q;
  logic [7:0]  video_ram_q;
  logic [7:0]  result_byte;

  always_comb begin
    op          = ccbd_pkg::op_t'(operation);
    in_ram      = address < ccbd_pkg::PPU_BASE;
    in_ppu      = !in_ram && (address < ccbd_pkg::IO_BASE);
    in_io       = (address >= ccbd_pkg::IO_BASE) && (address < ccbd_pkg::UNMAPPED_BASE);
    reg_num     = address[2:0];
    io_idx      = address[IO_IDX_W-1:0];
    cpu_off     = ccbd_pkg::wrap_index(address[12:0], 14'(CPU_RAM_BYTES));
    cpu_idx     = cpu_off[CPU_IDX_W-1:0];
    vram_wr_off = ccbd_pkg::wrap_index(video_address[12:0], 14'(VIDEO_RAM_BYTES));
    vram_wr_idx = vram_wr_off[VRAM_IDX_W-1:0];
    vram_rd_off = ccbd_pkg::wrap_index(address[12:0], 14'(VIDEO_RAM_BYTES));
    vram_rd_idx = vram_rd_off[VRAM_IDX_W-1:0];

    for (int i = 0; i < 8; i++) begin
      ppu_regs_next[i] = ppu_regs[i];
    end
    video_address_next = video_address;
    scroll_pair_next   = scroll_pair;
    button_state_next  = button_state;
    button_shift_next  = button_shift;
    cpu_we   = 1'b0;
    vram_we  = 1'b0;
    io_we    = 1'b0;
    byte_val = 8'd0;
    src      = ccbd_pkg::SRC_BYTE;
    unm      = 1'b0;

    case (op)
      ccbd_pkg::OP_CPU_WRITE, ccbd_pkg::OP_CPU_READ: begin
        if (in_ram) begin
          if (op == ccbd_pkg::OP_CPU_WRITE) begin
            cpu_we = 1'b1;
          end else begin
            src = ccbd_pkg::SRC_CPU_RAM;
          end
        end else if (in_ppu) begin
          if (op == ccbd_pkg::OP_CPU_WRITE) begin
            ppu_regs_next[reg_num] = data;
            case (reg_num)
              ccbd_pkg::REG_STATUS: begin
                ppu_regs_next[ccbd_pkg::REG_STATUS][ccbd_pkg::VBLANK_BIT] = 1'b0;
              end
              ccbd_pkg::REG_SCROLL: begin
                scroll_pair_next = {scroll_pair[7:0], data};
              end
              ccbd_pkg::REG_ADDR: begin
                video_address_next = {video_address[5:0], data};
              end
              ccbd_pkg::REG_DATA: begin
                vram_we = video_address[13];
                video_address_next = video_address +
                  (ppu_regs[ccbd_pkg::REG_CTRL][ccbd_pkg::CTRL_INC_BIT] ?
                   ccbd_pkg::INC_ROW : ccbd_pkg::INC_COL);
              end
              default: begin
              end
            endcase
          end else begin
            byte_val = ppu_regs[reg_num];
          end
        end else if (in_io) begin
          if (op == ccbd_pkg::OP_CPU_WRITE) begin
            io_we = 1'b1;
            if (address == ccbd_pkg::JOYPAD_ADDR) begin
              button_shift_next = button_state;
            end
          end else if (address == ccbd_pkg::JOYPAD_ADDR) begin
            byte_val          = {7'd0, button_shift[0]};
            button_shift_next = {1'b0, button_shift[7:1]};
          end else begin
            byte_val = io_bytes[io_idx];
          end
        end else begin
          unm = 1'b1;
        end
      end
      ccbd_pkg::OP_VRAM_READ: begin
        if (address[13]) begin
          src = ccbd_pkg::SRC_VRAM;
        end
      end
      ccbd_pkg::OP_SET_VBLANK: begin
        ppu_regs_next[ccbd_pkg::REG_STATUS][ccbd_pkg::VBLANK_BIT] = 1'b1;
      end
      ccbd_pkg::OP_CLEAR_VBLANK: begin
        ppu_regs_next[ccbd_pkg::REG_STATUS][ccbd_pkg::VBLANK_BIT] = 1'b0;
      end
      ccbd_pkg::OP_LOAD_BUTTONS: begin
        button_state_next = data;
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      for (int i = 0; i < 8; i++) begin
        ppu_regs[i] <= 8'd0;
      end
      for (int i = 0; i < IO_BYTES; i++) begin
        io_bytes[i] <= 8'd0;
      end
      video_address <= '0;
      scroll_pair   <= 16'd0;
      button_state  <= 8'd0;
      button_shift  <= 8'd0;
    end else if (cmd.accept) begin
      for (int i = 0; i < 8; i++) begin
        ppu_regs[i] <= ppu_regs_next[i];
      end
      if (io_we) begin
        io_bytes[io_idx] <= data;
      end
      video_address <= video_address_next;
      scroll_pair   <= scroll_pair_next;
      button_state  <= button_state_next;
      button_shift  <= button_shift_next;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.accept) begin
      pend_byte     <= byte_val;
      pend_src      <= src;
      pend_unmapped <= unm;
      pend_scroll   <= scroll_pair_next;
      pend_vblank   <= ppu_regs_next[ccbd_pkg::REG_STATUS][ccbd_pkg::VBLANK_BIT];
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.accept) begin
      if (cpu_we) begin
        cpu_ram[cpu_idx] <= data;
      end
      cpu_ram_q <= cpu_ram[cpu_idx];
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.accept) begin
      if (vram_we) begin
        video_ram[vram_wr_idx] <= data;
      end
      video_ram_q <= video_ram[vram_rd_idx];
    end
  end

  always_comb begin
    case (pend_src)
      ccbd_pkg::SRC_CPU_RAM: result_byte = cpu_ram_q;
      ccbd_pkg::SRC_VRAM:    result_byte = video_ram_q;
      default:               result_byte = pend_byte;
    endcase
  end

  always_ff @(posedge clk) begin
    if (cmd.load_out) begin
      read_data <= result_byte;
      unmapped  <= pend_unmapped;
      scroll_x  <= pend_scroll[15:8];
      scroll_y  <= pend_scroll[7:0];
      vblank    <= pend_vblank;
    end
  end

endmodule

`default_nettype wire

### hdl/console_cpu_bus_decoder.sv
// Top level of the console CPU bus decoder: sequencer plus datapath.
// Depends on ccbd_pkg, ccbd_ctrl and ccbd_datapath.
`timescale 1ns / 1ps
`default_nettype none

// Each request is taken on a valid/ready handshake and produces exactly one result. The
// work RAM and video RAM are read at the accepting clock edge, and the result moves into
// the output register once it is free. A new request is accepted in the same cycle that the
// previous result moves into the output register, so the block sustains one request per
// cycle while the result side keeps up; while a result waits for out_ready, in_ready is low.
// The 8 KB RAM arrays have no reset, and reading a byte that was never written returns
// an undefined value; the PPU and I/O registers, latch, scroll and buttons reset to zero.

module console_cpu_bus_decoder #(
  parameter int unsigned CPU_RAM_BYTES   = ccbd_pkg::CPU_RAM_BYTES_DEF,
  parameter int unsigned VIDEO_RAM_BYTES = ccbd_pkg::VIDEO_RAM_BYTES_DEF,
  parameter int unsigned IO_BYTES        = ccbd_pkg::IO_BYTES_DEF
) (
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire logic        in_valid,
  output logic             in_ready,
  input  wire logic [2:0]  operation,
  input  wire logic [15:0] address,
  input  wire logic [7:0]  data,
  output logic             out_valid,
  input  wire logic        out_ready,
  output logic      [7:0]  read_data,
  output logic             unmapped,
  output logic      [7:0]  scroll_x,
  output logic      [7:0]  scroll_y,
  output logic             vblank
);

  ccbd_pkg::cmd_t cmd;

  ccbd_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .cmd       (cmd)
  );

  ccbd_datapath #(
    .CPU_RAM_BYTES   (CPU_RAM_BYTES),
    .VIDEO_RAM_BYTES (VIDEO_RAM_BYTES),
    .IO_BYTES        (IO_BYTES)
  ) u_datapath (
    .clk       (clk),
    .rst       (rst),
    .cmd       (cmd),
    .operation (operation),
    .address   (address),
    .data      (data),
    .read_data (read_data),
    .unmapped  (unmapped),
    .scroll_x  (scroll_x),
    .scroll_y  (scroll_y),
    .vblank    (vblank)
  );

endmodule

`default_nettype wire

### sim/console_cpu_bus_decoder_tb.sv
// Self-checking testbench for console_cpu_bus_decoder: directed corner requests, then random
// bus traffic under several idling patterns, checked against an in-bench bus model.
// Depends on ccbd_pkg and the console_cpu_bus_decoder RTL.
`timescale 1ns / 1ps

module console_cpu_bus_decoder_tb;

  localparam int unsigned STALL_LIMIT  = 1000;
  localparam int unsigned SETTLE_CYCLES = 10;
  localparam int unsigned RAM_BYTES    = ccbd_pkg::CPU_RAM_BYTES_DEF;
  localparam int unsigned VRAM_BYTES   = ccbd_pkg::VIDEO_RAM_BYTES_DEF;
  localparam logic [2:0]  OP_RESERVED_A = 3'd6;
  localparam logic [2:0]  OP_RESERVED_B = 3'd7;

  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic        in_valid = 1'b0;
  logic        in_ready;
  logic [2:0]  operation = '0;
  logic [15:0] address = '0;
  logic [7:0]  data = '0;
  logic        out_valid;
  logic        out_ready = 1'b0;
  logic [7:0]  read_data;
  logic        unmapped;
  logic [7:0]  scroll_x;
  logic [7:0]  scroll_y;
  logic        vblank;

  typedef struct {
    logic [7:0] rdata;
    logic       unm;
    logic [7:0] sx;
    logic [7:0] sy;
    logic       vb;
  } bus_result_t;

  bus_result_t expected_results[$];

  logic [7:0]  work_ram [RAM_BYTES];
  bit          work_ram_valid [RAM_BYTES];
  logic [12:0] work_ram_used[$];
  logic [7:0]  vram [VRAM_BYTES];
  bit          vram_valid [VRAM_BYTES];
  logic [12:0] vram_used[$];
  logic [7:0]  ppu_regs [8] = '{default: 8'h00};
  logic [7:0]  io_regs [ccbd_pkg::IO_BYTES_DEF] = '{default: 8'h00};
  logic [13:0] vaddr_latch = '0;
  logic [15:0] scroll_latch = '0;
  logic [7:0]  pad_state = '0;
  logic [7:0]  pad_shift = '0;

  int unsigned src_idle_pct = 38;
  int unsigned sink_idle_pct = 50;
  int unsigned sent_count = 0;
  int unsigned results_checked = 0;
  int unsigned mismatch_count = 0;

  console_cpu_bus_decoder dut (
    .clk(clk),
    .rst(rst),
    .in_valid(in_valid),
    .in_ready(in_ready),
    .operation(operation),
    .address(address),
    .data(data),
    .out_valid(out_valid),
    .out_ready(out_ready),
    .read_data(read_data),
    .unmapped(unmapped),
    .scroll_x(scroll_x),
    .scroll_y(scroll_y),
    .vblank(vblank)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  function automatic void write_ppu_reg(input logic [2:0] regnum, input logic [7:0] val);
    ppu_regs[regnum] = val;
    case (regnum)
      ccbd_pkg::REG_STATUS: begin
        ppu_regs[ccbd_pkg::REG_STATUS][ccbd_pkg::VBLANK_BIT] = 1'b0;
      end
      ccbd_pkg::REG_SCROLL: begin
        scroll_latch = {scroll_latch[7:0], val};
      end
      ccbd_pkg::REG_ADDR: begin
        vaddr_latch = {vaddr_latch[5:0], val};
      end
      ccbd_pkg::REG_DATA: begin
        if (vaddr_latch[13]) begin
          vram[vaddr_latch[12:0]] = val;
          if (!vram_valid[vaddr_latch[12:0]]) begin
            vram_valid[vaddr_latch[12:0]] = 1'b1;
            vram_used.push_back(vaddr_latch[12:0]);
          end
        end
        vaddr_latch = vaddr_latch +
          (ppu_regs[ccbd_pkg::REG_CTRL][ccbd_pkg::CTRL_INC_BIT] ?
           ccbd_pkg::INC_ROW : ccbd_pkg::INC_COL);
      end
      default: begin
      end
    endcase
  endfunction

  function automatic bus_result_t predict_bus_access(input logic [2:0] op,
                                                     input logic [15:0] addr,
                                                     input logic [7:0] val);
    bus_result_t r;
    logic [4:0] io_idx;
    r.rdata = '0;
    r.unm = 1'b0;
    io_idx = addr[4:0];
    case (op)
      ccbd_pkg::OP_CPU_WRITE, ccbd_pkg::OP_CPU_READ: begin
        if (addr < ccbd_pkg::PPU_BASE) begin
          if (op == ccbd_pkg::OP_CPU_WRITE) begin
            work_ram[addr[12:0]] = val;
            if (!work_ram_valid[addr[12:0]]) begin
              work_ram_valid[addr[12:0]] = 1'b1;
              work_ram_used.push_back(addr[12:0]);
            end
          end else begin
            r.rdata = work_ram[addr[12:0]];
          end
        end else if (addr < ccbd_pkg::IO_BASE) begin
          if (op == ccbd_pkg::OP_CPU_WRITE) begin
            write_ppu_reg(addr[2:0], val);
          end else begin
            r.rdata = ppu_regs[addr[2:0]];
          end
        end else if (addr < ccbd_pkg::UNMAPPED_BASE) begin
          if (op == ccbd_pkg::OP_CPU_WRITE) begin
            if (addr == ccbd_pkg::JOYPAD_ADDR) begin
              pad_shift = pad_state;
            end
            io_regs[io_idx] = val;
          end else if (addr == ccbd_pkg::JOYPAD_ADDR) begin
            r.rdata = {7'b0, pad_shift[0]};
            pad_shift = pad_shift >> 1;
          end else begin
            r.rdata = io_regs[io_idx];
          end
        end else begin
          r.unm = 1'b1;
        end
      end
      ccbd_pkg::OP_VRAM_READ: begin
        if (addr[13]) begin
          r.rdata = vram[addr[12:0]];
        end
      end
      ccbd_pkg::OP_SET_VBLANK: begin
        ppu_regs[ccbd_pkg::REG_STATUS][ccbd_pkg::VBLANK_BIT] = 1'b1;
      end
      ccbd_pkg::OP_CLEAR_VBLANK: begin
        ppu_regs[ccbd_pkg::REG_STATUS][ccbd_pkg::VBLANK_BIT] = 1'b0;
      end
      ccbd_pkg::OP_LOAD_BUTTONS: begin
        pad_state = val;
      end
      default: begin
      end
    endcase
    r.sx = scroll_latch[15:8];
    r.sy = scroll_latch[7:0];
    r.vb = ppu_regs[ccbd_pkg::REG_STATUS][ccbd_pkg::VBLANK_BIT];
    return r;
  endfunction

  // Reads of RAM bytes that were never written are steered off RAM by flipping address bit 13.
  task automatic send_request(input logic [2:0] op, input logic [15:0] addr,
                              input logic [7:0] val);
    if (op == ccbd_pkg::OP_CPU_READ && addr < ccbd_pkg::PPU_BASE &&
        !work_ram_valid[addr[12:0]]) begin
      addr[13] = 1'b1;
    end
    if (op == ccbd_pkg::OP_VRAM_READ && addr[13] && !vram_valid[addr[12:0]]) begin
      addr[13] = 1'b0;
    end
    while ($urandom_range(99) < src_idle_pct) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid <= 1'b1;
    operation <= op;
    address <= addr;
    data <= val;
    @(posedge clk);
    while (!in_ready) begin
      @(posedge clk);
    end
    expected_results.push_back(predict_bus_access(op, addr, val));
    sent_count++;
  endtask

  task automatic drain_results();
    in_valid <= 1'b0;
    while (expected_results.size() != 0) begin
      @(posedge clk);
    end
  endtask

  function automatic logic [15:0] reg_addr(input logic [2:0] regnum);
    logic [9:0] mirror;
    mirror = 10'($urandom_range(1023));
    if ($urandom_range(1) == 0) begin
      mirror = '0;
    end
    return ccbd_pkg::PPU_BASE | {3'b000, mirror, regnum};
  endfunction

  function automatic logic [15:0] work_ram_addr();
    logic [15:0] a;
    a = 16'($urandom_range(ccbd_pkg::PPU_BASE - 16'd1));
    if (work_ram_used.size() != 0 && $urandom_range(3) != 0) begin
      a = {3'b000, work_ram_used[$urandom_range(work_ram_used.size() - 1)]};
    end
    return a;
  endfunction

  function automatic logic [15:0] vram_read_addr();
    logic [15:0] a;
    a = 16'($urandom_range(16'hFFFF));
    if (vram_used.size() != 0 && $urandom_range(3) != 0) begin
      a[13:0] = {1'b1, vram_used[$urandom_range(vram_used.size() - 1)]};
    end
    return a;
  endfunction

  function automatic logic [7:0] rand_byte();
    return 8'($urandom_range(255));
  endfunction

  function automatic logic [15:0] rand_addr();
    return 16'($urandom_range(16'hFFFF));
  endfunction

  task automatic test_work_ram();
    send_request(ccbd_pkg::OP_CPU_WRITE, 16'h0000, 8'h00);
    send_request(ccbd_pkg::OP_CPU_WRITE, ccbd_pkg::PPU_BASE - 16'd1, 8'hFF);
    send_request(ccbd_pkg::OP_CPU_READ, 16'h0000, 8'hFF);
    send_request(ccbd_pkg::OP_CPU_READ, ccbd_pkg::PPU_BASE - 16'd1, 8'h00);
  endtask

  task automatic test_video_port();
    send_request(ccbd_pkg::OP_CPU_WRITE, 16'h3FF8 | ccbd_pkg::REG_ADDR, 8'h3F);
    send_request(ccbd_pkg::OP_CPU_WRITE, ccbd_pkg::PPU_BASE | ccbd_pkg::REG_ADDR, 8'hFF);
    send_request(ccbd_pkg::OP_CPU_WRITE, ccbd_pkg::PPU_BASE | ccbd_pkg::REG_DATA, 8'hA5);
    send_request(ccbd_pkg::OP_CPU_WRITE, ccbd_pkg::PPU_BASE | ccbd_pkg::REG_CTRL, 8'h04);
    send_request(ccbd_pkg::OP_CPU_WRITE, 16'h3FF8 | ccbd_pkg::REG_DATA, 8'h5A);
    send_request(ccbd_pkg::OP_VRAM_READ, 16'hFFFF, 8'hFF);
    send_request(ccbd_pkg::OP_VRAM_READ, 16'h0000, 8'h00);
  endtask

  task automatic test_scroll_and_vblank();
    send_request(ccbd_pkg::OP_CPU_WRITE, ccbd_pkg::PPU_BASE | ccbd_pkg::REG_SCROLL, 8'h12);
    send_request(ccbd_pkg::OP_CPU_WRITE, 16'h3FF8 | ccbd_pkg::REG_SCROLL, 8'h34);
    send_request(ccbd_pkg::OP_SET_VBLANK, 16'h0000, 8'h00);
    send_request(ccbd_pkg::OP_CPU_READ, ccbd_pkg::PPU_BASE | ccbd_pkg::REG_STATUS, 8'h00);
    send_request(ccbd_pkg::OP_CPU_WRITE, ccbd_pkg::PPU_BASE | ccbd_pkg::REG_STATUS, 8'hFF);
    send_request(ccbd_pkg::OP_CPU_READ, 16'h3FF8 | ccbd_pkg::REG_STATUS, 8'h00);
    send_request(ccbd_pkg::OP_SET_VBLANK, 16'hFFFF, 8'hFF);
    send_request(ccbd_pkg::OP_CLEAR_VBLANK, 16'hFFFF, 8'hFF);
  endtask

  task automatic test_unmapped_and_spare_ops();
    send_request(ccbd_pkg::OP_CPU_WRITE, ccbd_pkg::UNMAPPED_BASE, 8'hFF);
    send_request(ccbd_pkg::OP_CPU_READ, 16'hFFFF, 8'h00);
    send_request(ccbd_pkg::OP_CPU_READ, ccbd_pkg::UNMAPPED_BASE - 16'd1, 8'h00);
    send_request(OP_RESERVED_A, 16'hFFFF, 8'hFF);
    send_request(OP_RESERVED_B, 16'h0000, 8'h00);
  endtask

  task automatic test_joypad();
    send_request(ccbd_pkg::OP_LOAD_BUTTONS, 16'h0000, 8'hA5);
    send_request(ccbd_pkg::OP_CPU_WRITE, ccbd_pkg::JOYPAD_ADDR, 8'h00);
    repeat (3) begin
      send_request(ccbd_pkg::OP_CPU_READ, ccbd_pkg::JOYPAD_ADDR, 8'h00);
    end
  endtask

  // Mostly well-formed register sequences with random content, plus raw noise.
  task automatic test_random_traffic(input int unsigned count);
    int unsigned stop_at;
    int unsigned pick;
    int unsigned reps;
    logic [7:0] hi;
    stop_at = sent_count + count;
    while (sent_count < stop_at) begin
      pick = $urandom_range(99);
      if (pick < 22) begin
        if ($urandom_range(2) == 0) begin
          send_request(ccbd_pkg::OP_CPU_WRITE, reg_addr(ccbd_pkg::REG_CTRL), rand_byte());
        end
        hi = rand_byte();
        if ($urandom_range(9) < 7) begin
          hi[5] = 1'b1;
        end
        send_request(ccbd_pkg::OP_CPU_WRITE, reg_addr(ccbd_pkg::REG_ADDR), hi);
        send_request(ccbd_pkg::OP_CPU_WRITE, reg_addr(ccbd_pkg::REG_ADDR), rand_byte());
        reps = $urandom_range(6, 1);
        repeat (reps) begin
          send_request(ccbd_pkg::OP_CPU_WRITE, reg_addr(ccbd_pkg::REG_DATA), rand_byte());
        end
        reps = $urandom_range(3, 1);
        repeat (reps) begin
          send_request(ccbd_pkg::OP_VRAM_READ, vram_read_addr(), rand_byte());
        end
      end else if (pick < 38) begin
        send_request(ccbd_pkg::OP_CPU_WRITE,
                     16'($urandom_range(ccbd_pkg::PPU_BASE - 16'd1)), rand_byte());
        reps = $urandom_range(3, 1);
        repeat (reps) begin
          send_request(ccbd_pkg::OP_CPU_READ, work_ram_addr(), rand_byte());
        end
      end else if (pick < 48) begin
        send_request(ccbd_pkg::OP_LOAD_BUTTONS, rand_addr(), rand_byte());
        send_request(ccbd_pkg::OP_CPU_WRITE, ccbd_pkg::JOYPAD_ADDR, rand_byte());
        if ($urandom_range(3) == 0) begin
          send_request(ccbd_pkg::OP_LOAD_BUTTONS, rand_addr(), rand_byte());
        end
        reps = $urandom_range(10, 1);
        repeat (reps) begin
          send_request(ccbd_pkg::OP_CPU_READ, ccbd_pkg::JOYPAD_ADDR, rand_byte());
        end
      end else if (pick < 56) begin
        reps = $urandom_range(3, 1);
        repeat (reps) begin
          send_request(ccbd_pkg::OP_CPU_WRITE, reg_addr(ccbd_pkg::REG_SCROLL), rand_byte());
        end
      end else if (pick < 66) begin
        send_request(ccbd_pkg::OP_SET_VBLANK, rand_addr(), rand_byte());
        send_request(ccbd_pkg::OP_CPU_READ, reg_addr(3'($urandom_range(7))), rand_byte());
        if ($urandom_range(1) == 0) begin
          send_request(ccbd_pkg::OP_CPU_WRITE, reg_addr(ccbd_pkg::REG_STATUS), rand_byte());
        end else begin
          send_request(ccbd_pkg::OP_CLEAR_VBLANK, rand_addr(), rand_byte());
        end
        send_request(ccbd_pkg::OP_CPU_READ, reg_addr(ccbd_pkg::REG_STATUS), rand_byte());
      end else if (pick < 78) begin
        send_request(3'($urandom_range(1)),
                     ccbd_pkg::IO_BASE + 16'($urandom_range(ccbd_pkg::IO_BYTES_DEF - 1)),
                     rand_byte());
      end else if (pick < 88) begin
        send_request(3'($urandom_range(1)),
                     16'($urandom_range(16'hFFFF, ccbd_pkg::UNMAPPED_BASE)), rand_byte());
      end else begin
        send_request(3'($urandom_range(7)), rand_addr(), rand_byte());
      end
    end
  endtask

  function automatic void check_field(input string name, input logic [7:0] want,
                                      input logic [7:0] got);
    if (got !== want) begin
      mismatch_count++;
      $display("%0t: %s mismatch, expected 0x%02h, actual 0x%02h", $time, name, want, got);
    end
  endfunction

  always @(posedge clk) begin
    bus_result_t want;
    if (rst) begin
      out_ready <= 1'b0;
    end else begin
      if (out_valid && out_ready) begin
        if (expected_results.size() == 0) begin
          mismatch_count++;
          $display("%0t: unexpected result, expected none, actual read_data 0x%02h",
                   $time, read_data);
        end else begin
          want = expected_results.pop_front();
          results_checked++;
          check_field("read_data", want.rdata, read_data);
          check_field("unmapped", {7'b0, want.unm}, {7'b0, unmapped});
          check_field("scroll_x", want.sx, scroll_x);
          check_field("scroll_y", want.sy, scroll_y);
          check_field("vblank", {7'b0, want.vb}, {7'b0, vblank});
        end
      end
      out_ready <= ($urandom_range(99) >= sink_idle_pct);
    end
  end

  initial begin : watchdog
    int unsigned quiet_cycles;
    quiet_cycles = 0;
    while (quiet_cycles < STALL_LIMIT) begin
      @(posedge clk);
      if ((in_valid && in_ready) || (out_valid && out_ready)) begin
        quiet_cycles = 0;
      end else begin
        quiet_cycles++;
      end
    end
    $display("%0t: no request or result moved for %0d cycles", $time, STALL_LIMIT);
    $display("[FAIL] regression broken");
    $finish;
  end

  initial begin
    repeat (3) @(posedge clk);
    rst <= 1'b0;
    test_work_ram();
    test_video_port();
    test_scroll_and_vblank();
    test_unmapped_and_spare_ops();
    test_joypad();
    test_random_traffic(220);
    drain_results();
    src_idle_pct = 50;
    sink_idle_pct = 38;
    test_random_traffic(220);
    drain_results();
    src_idle_pct = 0;
    sink_idle_pct = 0;
    test_random_traffic(210);
    drain_results();
    repeat (SETTLE_CYCLES) @(posedge clk);
    $display("Sent %0d requests over work RAM, picture registers and mirrors, video RAM,",
             sent_count);
    $display("scroll, VBlank, joypad, I/O and unmapped space; %0d results checked, %0d errors.",
             results_checked, mismatch_count);
    if (mismatch_count == 0 && expected_results.size() == 0) begin
      $display("[ OK ] regression clean");
    end else begin
      $display("[FAIL] regression broken");
    end
    $finish;
  end

endmodule
